// ===== rtl/lots_pkg.sv =====
// Shared types, constants and command/status structs for the letter order sorter.
package lots_pkg;
  localparam int Alphabet     = 26;
  localparam int MaxWordsDef  = 128;
  localparam int MaxWordLenDef = 32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_IMPOSS   = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic load;        // store the input item
    logic cmp_start;   // load pair compare for (wi, wj)
    logic cmp_step;    // advance position in pair compare
    logic mem_rd;      // read both letters at position
    logic srch_init;   // reset search pointers
    logic srch_step;   // do one search step
    logic emit_pop;    // advance emit pointer
    logic clear_step;  // clear one row of matrix and marks
    logic clear_run;   // reset counters
  } lots_cmd_t;

  typedef struct packed {
    logic overflow;
    logic pairs_done;  // no more pairs
    logic cmp_done;    // current pair resolved
    logic prefix_bad;  // prefix violation
    logic srch_done;
    logic srch_cycle;
    logic emit_last;
    logic clear_done;
  } lots_sts_t;
endpackage

// ===== rtl/lots_if.sv =====
// Valid/ready channel interfaces for the letter order sorter.
interface lots_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter;
  logic       word_end;
  logic       list_end;
  modport source (output valid, letter, word_end, list_end, input ready);
  modport sink   (input valid, letter, word_end, list_end, output ready);
endinterface

interface lots_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_letter;
  logic [1:0] status;
  logic       last;
  modport source (output valid, out_letter, status, last, input ready);
  modport sink   (input valid, out_letter, status, last, output ready);
endinterface

// ===== rtl/letter_order_topological_sort.sv =====
// Letter order sorter: loads a word list, derives letter precedence, sorts it.
// Sequence: letters load one per cycle; after the list end each word pair is compared
//   letter position by letter position, then a depth-first search runs, then 26 results
//   go out at one per cycle while out_ready is high, or one result on overflow or when
//   no order exists; a clear of the 26 matrix rows and visit marks follows.
// Throughput: one run at a time; the input stalls from the list end to the clear.
// Reset: synchronous active-high rst empties counters, matrix and visit marks.
module letter_order_topological_sort #(
  parameter int MaxWords   = lots_pkg::MaxWordsDef,
  parameter int MaxWordLen = lots_pkg::MaxWordLenDef
) (
  input logic         clk,
  input logic         rst,
  lots_in_if.sink     in_ch,
  lots_out_if.source  out_ch
);
  lots_pkg::lots_cmd_t cmd;
  lots_pkg::lots_sts_t sts;
  logic [4:0] emit_letter;
  logic [1:0] status;
  logic       last_sel;
  logic       ovalid;

  // Sequence the run.
  lots_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_list_end(in_ch.list_end), .in_ready(in_ch.ready),
    .out_valid(ovalid), .out_ready(out_ch.ready),
    .out_status(status), .out_last_sel(last_sel),
    .cmd(cmd), .sts(sts)
  );

  // Hold the words, matrix and search state.
  lots_datapath #(.MaxWords(MaxWords), .MaxWordLen(MaxWordLen)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .letter(in_ch.letter), .word_end(in_ch.word_end), .list_end(in_ch.list_end),
    .emit_letter(emit_letter)
  );

  // Drive the letter only on a valid order; errors show zero.
  assign out_ch.valid      = ovalid;
  assign out_ch.status     = status;
  assign out_ch.last       = last_sel;
  assign out_ch.out_letter = (status == lots_pkg::STATUS_OK) ? emit_letter : 5'd0;
endmodule

// ===== rtl/lots_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module lots_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== rtl/lots_datapath.sv =====
// Datapath: word store, pair compare, adjacency matrix, search stack and postorder.
module lots_datapath #(
  parameter int MaxWords   = lots_pkg::MaxWordsDef,
  parameter int MaxWordLen = lots_pkg::MaxWordLenDef
) (
  input  logic                clk,
  input  logic                rst,
  input  lots_pkg::lots_cmd_t cmd,
  output lots_pkg::lots_sts_t sts,
  input  logic [4:0]          letter,
  input  logic                word_end,
  input  logic                list_end,
  output logic [4:0]          emit_letter
);
  localparam int A   = lots_pkg::Alphabet;
  localparam int WiW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int CW  = $clog2(MaxWords + 1);
  localparam int PiW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int PW  = $clog2(MaxWordLen + 1);
  localparam int Depth = MaxWords * MaxWordLen;
  localparam int SW  = $clog2(Depth);

  // input side
  logic [CW-1:0] word_count;
  logic [PW-1:0] letter_position;
  logic          overflow_seen;
  logic [4:0]    let_sat;
  logic          w_end;
  logic          fits;

  // word lengths held in a RAM, read at (wi, wj)
  logic          len_we;
  logic [PW-1:0] len_wdata;
  logic [PW-1:0] li, lj;

  // pair compare
  logic [CW-1:0] wi, wj;
  logic [PW-1:0] pos, lim;
  logic          len_i_gt;
  logic          pending;     // read outstanding
  logic [4:0]    rd_a, rd_b;
  logic [SW-1:0] ra, rb, waddr;

  logic [A-1:0]  adj [A];
  logic [1:0]    marks [A];
  logic [4:0]    clr_idx;

  // search
  logic [4:0]    root;
  logic [4:0]    stk_v [A];
  logic [4:0]    stk_u [A];
  logic [4:0]    sp;
  logic [4:0]    post [A];
  logic [4:0]    post_cnt;
  logic          srch_done, srch_cycle;
  logic [4:0]    emit_idx;

  assign let_sat = (letter > 5'(A - 1)) ? 5'(A - 1) : letter;
  assign w_end   = word_end | list_end;
  assign fits    = (word_count < CW'(MaxWords)) && (letter_position < PW'(MaxWordLen));
  assign waddr   = SW'(word_count[WiW-1:0]) * SW'(MaxWordLen) + SW'(letter_position[PiW-1:0]);
  assign ra      = SW'(wi[WiW-1:0]) * SW'(MaxWordLen) + SW'(pos[PiW-1:0]);
  assign rb      = SW'(wj[WiW-1:0]) * SW'(MaxWordLen) + SW'(pos[PiW-1:0]);

  assign len_we    = cmd.load && w_end && (word_count < CW'(MaxWords));
  assign len_wdata = fits ? letter_position + 1'b1 : letter_position;

  lots_ram #(.Width(5), .Depth(Depth)) u_store (
    .clk(clk), .we(cmd.load && fits), .waddr(waddr), .wdata(let_sat),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rd_a), .rdata_b(rd_b)
  );

  lots_ram #(.Width(PW), .Depth(MaxWords)) u_lengths (
    .clk(clk), .we(len_we), .waddr(word_count[WiW-1:0]), .wdata(len_wdata),
    .raddr_a(wi[WiW-1:0]), .raddr_b(wj[WiW-1:0]), .rdata_a(li), .rdata_b(lj)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      word_count      <= '0;
      letter_position <= '0;
      overflow_seen   <= 1'b0;
    end else if (cmd.load) begin
      if (!fits) overflow_seen <= 1'b1;
      if (w_end) begin
        letter_position <= '0;
        if (word_count < CW'(MaxWords)) begin
          word_count <= word_count + 1'b1;
        end
      end else if (fits) begin
        letter_position <= letter_position + 1'b1;
      end
    end
  end

  // Pair compare: wi/wj walk pairs; each letter pair goes through read, check and next.
  logic          cmp_done, prefix_bad;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      wi <= '0;
      wj <= CW'(1);
      cmp_done <= 1'b0;
      prefix_bad <= 1'b0;
      pending <= 1'b0;
    end else if (cmd.cmp_start) begin
      pos      <= '0;
      lim      <= (li < lj) ? li : lj;
      len_i_gt <= li > lj;
      cmp_done <= 1'b0;
      pending  <= 1'b0;
    end else if (cmd.mem_rd) begin
      if (pos >= lim) begin
        cmp_done <= 1'b1;
        if (len_i_gt) prefix_bad <= 1'b1;
      end else begin
        pending <= 1'b1;
      end
    end else if (cmd.cmp_step && pending) begin
      pending <= 1'b0;
      if (rd_a != rd_b) begin
        cmp_done <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end else if (cmd.emit_pop) begin
      // unused path
    end
    // advance pair once resolved
    if (!rst && !cmd.clear_run && cmp_done && !cmd.cmp_start && !cmd.mem_rd &&
        !cmd.cmp_step) begin
      cmp_done <= 1'b0;
      if (wj + 1'b1 >= word_count) begin
        wi <= wi + 1'b1;
        wj <= wi + CW'(2);
      end else begin
        wj <= wj + 1'b1;
      end
    end
  end

  // Adjacency, marks and search.
  logic [4:0] tv, tu, nu;
  logic       found;
  logic [A-1:0] row_mask;
  always_comb begin
    tv = stk_v[sp - 5'd1];
    tu = stk_u[sp - 5'd1];
    found = 1'b0;
    nu = '0;
    for (int k = A - 1; k >= 0; k--) begin
      if (5'(k) >= tu && 5'(k) != tv && adj[tv][k] && marks[k] != 2'd2) begin
        found = 1'b1;
        nu = 5'(k);
      end
    end
    row_mask = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < A; k++) begin
        adj[k]   <= '0;
        marks[k] <= 2'd0;
      end
      clr_idx <= '0;
      srch_done <= 1'b0;
      srch_cycle <= 1'b0;
      sp <= '0;
      root <= 5'(A - 1);
      post_cnt <= '0;
      emit_idx <= '0;
    end else begin
      if (cmd.cmp_step && pending && rd_a != rd_b) begin
        adj[rd_a][rd_b] <= 1'b1;
      end
      if (cmd.clear_step) begin
        adj[clr_idx]   <= row_mask;
        marks[clr_idx] <= 2'd0;
        clr_idx <= (clr_idx == 5'(A - 1)) ? '0 : clr_idx + 1'b1;
      end
      if (cmd.srch_init) begin
        sp <= '0;
        root <= 5'(A - 1);
        post_cnt <= '0;
        srch_done <= 1'b0;
        srch_cycle <= 1'b0;
        emit_idx <= 5'(A - 1);
      end else if (cmd.srch_step && !srch_done) begin
        if (sp == '0) begin
          if (marks[root] == 2'd0) begin
            marks[root] <= 2'd1;
            stk_v[0] <= root;
            stk_u[0] <= '0;
            sp <= 5'd1;
          end
          if (root == '0) begin
            if (marks[root] != 2'd0) srch_done <= 1'b1;
          end else begin
            root <= root - 1'b1;
          end
        end else if (found) begin
          if (marks[nu] == 2'd1) begin
            srch_cycle <= 1'b1;
            srch_done  <= 1'b1;
          end else begin
            stk_u[sp - 5'd1] <= nu + 1'b1;
            marks[nu] <= 2'd1;
            stk_v[sp] <= nu;
            stk_u[sp] <= '0;
            sp <= sp + 1'b1;
          end
        end else begin
          marks[tv] <= 2'd2;
          post[post_cnt] <= tv;
          post_cnt <= post_cnt + 1'b1;
          sp <= sp - 1'b1;
          if (sp == 5'd1 && root == '0 && marks[root] != 2'd0 &&
              stk_v[0] == '0) begin
            srch_done <= 1'b1;
          end
        end
      end
      if (cmd.emit_pop) emit_idx <= emit_idx - 1'b1;
    end
  end

  // Root a pushed last: done once stack empties with root a visited.
  assign emit_letter     = post[emit_idx];
  assign sts.overflow    = overflow_seen;
  assign sts.pairs_done  = (wi + 1'b1 >= word_count);
  assign sts.cmp_done    = cmp_done;
  assign sts.prefix_bad  = prefix_bad;
  assign sts.srch_done   = srch_done || (sp == '0 && root == '0 && marks[0] != 2'd0);
  assign sts.srch_cycle  = srch_cycle;
  assign sts.emit_last   = (emit_idx == '0);
  assign sts.clear_done  = (clr_idx == 5'(A - 1));
endmodule

// ===== rtl/lots_ctrl.sv =====
// Controller state machine sequencing load, compare, search, emit and clear.
module lots_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_list_end,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic                out_last_sel,
  output lots_pkg::lots_cmd_t cmd,
  input  lots_pkg::lots_sts_t sts
);
  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_PAIR   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_SINIT  = 4'd5;
  localparam logic [3:0] S_SRCH   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_ONE    = 4'd8;
  localparam logic [3:0] S_CLEAR  = 4'd9;
  localparam logic [3:0] S_LEN    = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] stat, stat_next;

  always_comb begin
    state_next = state;
    stat_next  = stat;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last_sel = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_list_end) state_next = S_PAIR;
      end
      S_PAIR: begin
        if (sts.overflow) begin
          stat_next = lots_pkg::STATUS_OVERFLOW;
          state_next = S_ONE;
        end else if (sts.prefix_bad) begin
          stat_next = lots_pkg::STATUS_IMPOSS;
          state_next = S_ONE;
        end else if (sts.pairs_done) begin
          state_next = S_SINIT;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        // word lengths of the pair are readable now
        cmd.cmp_start = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.cmp_step = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sts.cmp_done) state_next = S_PAIR;
        else state_next = S_RD;
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        if (sts.srch_cycle) begin
          stat_next = lots_pkg::STATUS_IMPOSS;
          state_next = S_ONE;
        end else if (sts.srch_done) begin
          stat_next = lots_pkg::STATUS_OK;
          state_next = S_EMIT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_last_sel = sts.emit_last;
        if (out_ready) begin
          cmd.emit_pop = 1'b1;
          if (sts.emit_last) state_next = S_CLEAR;
        end
      end
      S_ONE: begin
        out_valid = 1'b1;
        out_last_sel = 1'b1;
        if (out_ready) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          cmd.clear_run = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  assign out_status = stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      stat  <= lots_pkg::STATUS_OK;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end
endmodule

// ===== rtl/lots_checker.sv =====
// Port-level checker for the letter order sorter, bound to the top level.
module lots_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_letter,
  input logic [1:0] status,
  input logic       last
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lots_pkg::STATUS_OK |-> last) else $error("error not last");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lots_pkg::STATUS_OK |-> out_letter == 5'd0)
    else $error("error letter nonzero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind letter_order_topological_sort lots_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_letter(out_ch.out_letter),
  .status(out_ch.status), .last(out_ch.last)
);
